// File: hw/rtl/glzw_pkg.sv
// Shared types, constants and helper functions for the GIF LZW code encoder.
// Used by the encoder top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package glzw_pkg;

  // Parameter defaults.
  localparam int DictCodesDef   = 4096;
  localparam int MaxWidthDef    = 12;
  localparam int HashBucketsDef = 4096;

  // Fixed field widths.
  localparam int PixelW = 8;
  localparam int CodeW  = 12;
  localparam int CwW    = 4;
  localparam int BitsW  = 4;
  localparam int FreeW  = 13;
  localparam int KeyW   = CodeW + PixelW;
  localparam int HashW  = 14;
  localparam int EntryW = 1 + KeyW + CodeW;

  // Register map.
  localparam int RegPixelBits = 0;
  localparam logic [BitsW-1:0] PixelBitsRst = 4'd4;

  // Clamp pixel_bits to the legal range of one to eight.
  function automatic logic [BitsW-1:0] eff_bits(input logic [BitsW-1:0] b);
    logic [BitsW-1:0] r;
    r = b;
    if (b == 4'd0) r = 4'd1;
    if (b > 4'd8) r = 4'd8;
    return r;
  endfunction

  // Mask for the low b bits of a pixel index.
  function automatic logic [PixelW-1:0] pix_mask(input logic [BitsW-1:0] b);
    logic [PixelW:0] m;
    m = (9'd1 << b) - 9'd1;
    return m[PixelW-1:0];
  endfunction

  // Clear code for a given pixel width.
  function automatic logic [CodeW-1:0] clear_for_bits(input logic [BitsW-1:0] b);
    return 12'd1 << b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gif_lzw_code_encoder.sv
// Top level of the GIF LZW code encoder: sequencer, hash probe and output register.
// Depends on glzw_pkg and glzw_ram.
//
//  channel  | direction | signals                                  | transfer when
//  ---------+-----------+------------------------------------------+------------------------
//  pixel in | input     | pixel_i, last_pixel_i                    | in_valid_i & in_ready_o
//  code out | output    | code_value_o, code_width_o, image_end_o  | out_valid_o & out_ready_i
//  config   | APB       | psel, penable, pwrite, paddr, pwdata     | psel & penable & pwrite
//
// A pixel that extends a phrase passes through accept, hash, then a read and a
// compare of the dictionary RAM (a further read and compare per collision); the
// hash subtracts until in range, needed only when HASH_BUCKETS or DICT_CODES is below 4096.
// A miss emits the finished code; the output register holds each code.
// The first pixel of an image and a dictionary restart sweep all DICT_CODES entries
// of the RAM. Reset clears registers, not the RAM; a stalled output holds the emitter.
`timescale 1ns / 1ps
`default_nettype none
module gif_lzw_code_encoder #(
  parameter int DICT_CODES   = glzw_pkg::DictCodesDef,
  parameter int MAX_WIDTH    = glzw_pkg::MaxWidthDef,
  parameter int HASH_BUCKETS = glzw_pkg::HashBucketsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Pixel channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  pixel_i,
  input  wire logic        last_pixel_i,
  // Code channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      code_value_o,
  output logic [3:0]       code_width_o,
  output logic             image_end_o,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SlotW = $clog2(DICT_CODES);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SWEEP, S_HASH, S_PROBE, S_CHECK,
    S_MISS, S_FULL, S_LAST_PFX, S_LAST_END
  } state_e;

  state_e state_q, state_d;
  logic [glzw_pkg::BitsW-1:0]  pbits_q, pbits_d;
  logic [glzw_pkg::BitsW-1:0]  bits_q, bits_d;
  logic [glzw_pkg::FreeW-1:0]  free_q, free_d;
  logic [glzw_pkg::CwW-1:0]    width_q, width_d;
  logic [glzw_pkg::CodeW-1:0]  prefix_q, prefix_d;
  logic                        started_q, started_d;
  logic [glzw_pkg::PixelW-1:0] pix_q, pix_d;
  logic                        last_q, last_d;
  logic [glzw_pkg::HashW-1:0]  hash_q, hash_d;
  logic [SlotW-1:0]            slot_q, slot_d;
  logic [SlotW-1:0]            cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [glzw_pkg::CodeW-1:0]  code_q, code_d;
  logic [glzw_pkg::CwW-1:0]    cwidth_q, cwidth_d;
  logic                        end_q, end_d;

  logic                         ram_we;
  logic [SlotW-1:0]             ram_waddr;
  logic [glzw_pkg::EntryW-1:0]  ram_wdata;
  logic [glzw_pkg::EntryW-1:0]  ram_rdata;

  logic                         cfg_wr;
  logic                         out_free;
  logic [glzw_pkg::CwW-1:0]     width_grown;
  logic [glzw_pkg::KeyW-1:0]    key_cur;
  logic [glzw_pkg::BitsW-1:0]   eb;
  logic [glzw_pkg::PixelW-1:0]  new_pix;
  logic [glzw_pkg::CodeW-1:0]   hash_src;
  logic [glzw_pkg::CodeW-1:0]   clr;

  // Dictionary storage: {valid, key, code}.
  glzw_ram #(
    .WIDTH (glzw_pkg::EntryW),
    .DEPTH (DICT_CODES)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(glzw_pkg::RegPixelBits));
  assign prdata = (paddr[2] == 1'(glzw_pkg::RegPixelBits)) ? {28'd0, pbits_q} : 32'd0;

  // Shared helpers for the sequencer.
  assign out_free    = !out_valid_q || out_ready_i;
  assign width_grown = ((32'(width_q) < MAX_WIDTH) &&
                        (free_q == (13'd1 << width_q))) ? width_q + 4'd1 : width_q;
  assign key_cur     = {prefix_q, pix_q};
  assign eb          = glzw_pkg::eff_bits(pbits_q);
  assign new_pix     = pixel_i & glzw_pkg::pix_mask(bits_q);
  assign hash_src    = prefix_q ^ {new_pix, 4'd0};
  assign clr         = glzw_pkg::clear_for_bits(bits_q);

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    pbits_d     = cfg_wr ? pwdata[3:0] : pbits_q;
    bits_d      = bits_q;
    free_d      = free_q;
    width_d     = width_q;
    prefix_d    = prefix_q;
    started_d   = started_q;
    pix_d       = pix_q;
    last_d      = last_q;
    hash_d      = hash_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    code_d      = code_q;
    cwidth_d    = cwidth_q;
    end_d       = end_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = {1'b1, key_cur, free_q[glzw_pkg::CodeW-1:0]};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_pixel_i;
          if (!started_q) begin
            bits_d  = eb;
            free_d  = 13'(glzw_pkg::clear_for_bits(eb)) + 13'd2;
            width_d = eb + 4'd1;
            pix_d   = pixel_i & glzw_pkg::pix_mask(eb);
            state_d = S_START;
          end else begin
            pix_d   = new_pix;
            hash_d  = glzw_pkg::HashW'(hash_src);
            state_d = S_HASH;
          end
        end
      end
      S_START: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          code_d      = clr;
          cwidth_d    = width_q;
          end_d       = 1'b0;
          width_d     = width_grown;
          prefix_d    = {4'd0, pix_q};
          started_d   = 1'b1;
          cnt_d       = '0;
          state_d     = S_SWEEP;
        end
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
        if (32'(cnt_q) == DICT_CODES - 1) begin
          state_d = last_q ? S_LAST_PFX : S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_HASH: begin
        // Reduce the hash into range, one subtraction per cycle.
        if (hash_q >= glzw_pkg::HashW'(HASH_BUCKETS)) begin
          hash_d = hash_q - glzw_pkg::HashW'(HASH_BUCKETS);
        end else if (hash_q >= glzw_pkg::HashW'(DICT_CODES)) begin
          hash_d = hash_q - glzw_pkg::HashW'(DICT_CODES);
        end else begin
          slot_d  = hash_q[SlotW-1:0];
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!ram_rdata[glzw_pkg::EntryW-1]) begin
          state_d = S_MISS;
        end else if (ram_rdata[glzw_pkg::EntryW-2:glzw_pkg::CodeW] == key_cur) begin
          prefix_d = ram_rdata[glzw_pkg::CodeW-1:0];
          state_d  = last_q ? S_LAST_PFX : S_IDLE;
        end else begin
          slot_d  = (32'(slot_q) == DICT_CODES - 1) ? '0 : slot_q + 1'b1;
          state_d = S_PROBE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          code_d      = prefix_q;
          cwidth_d    = width_q;
          end_d       = 1'b0;
          width_d     = width_grown;
          prefix_d    = {4'd0, pix_q};
          if (32'(free_q) >= DICT_CODES) begin
            state_d = S_FULL;
          end else begin
            ram_we  = 1'b1;
            free_d  = free_q + 13'd1;
            state_d = last_q ? S_LAST_PFX : S_IDLE;
          end
        end
      end
      S_FULL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          code_d      = clr;
          cwidth_d    = width_q;
          end_d       = 1'b0;
          free_d      = 13'(clr) + 13'd2;
          width_d     = bits_q + 4'd1;
          cnt_d       = '0;
          state_d     = S_SWEEP;
        end
      end
      S_LAST_PFX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          code_d      = prefix_q;
          cwidth_d    = width_q;
          end_d       = 1'b0;
          width_d     = width_grown;
          state_d     = S_LAST_END;
        end
      end
      S_LAST_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          code_d      = clr + 12'd1;
          cwidth_d    = width_q;
          end_d       = 1'b1;
          width_d     = width_grown;
          started_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, control, payload and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pbits_q     <= glzw_pkg::PixelBitsRst;
      bits_q      <= glzw_pkg::PixelBitsRst;
      free_q      <= 13'd18;
      width_q     <= 4'd5;
      prefix_q    <= '0;
      started_q   <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pix_q       <= '0;
      hash_q      <= '0;
      slot_q      <= '0;
      code_q      <= '0;
      cwidth_q    <= '0;
      end_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      pbits_q     <= pbits_d;
      bits_q      <= bits_d;
      free_q      <= free_d;
      width_q     <= width_d;
      prefix_q    <= prefix_d;
      started_q   <= started_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      pix_q       <= pix_d;
      hash_q      <= hash_d;
      slot_q      <= slot_d;
      code_q      <= code_d;
      cwidth_q    <= cwidth_d;
      end_q       <= end_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_value_o = code_q;
  assign code_width_o = cwidth_q;
  assign image_end_o  = end_q;

  // The next free code never runs past the dictionary size.
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_q) <= DICT_CODES)
    else $error("free code beyond dictionary");

  // The code width stays within its bounds.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_width_o >= 4'd2) && (32'(code_width_o) <= MAX_WIDTH))
    else $error("code width out of range");

  // The sequencer never begins emitting while an unread code would be lost.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (code_q == $past(code_q)))
    else $error("pending code overwritten");

endmodule
`default_nettype wire

// File: hw/rtl/glzw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the LZW dictionary entries; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module glzw_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
